@@ rtl/aeps_pkg.sv @@
// Shared constants, codes and types for the active/expired priority scheduler.
package aeps_pkg;

   localparam int LEVELS      = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_COUNT  = 256;

   localparam int ID_W    = $clog2(TASK_COUNT);
   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = 1 + LVL_W + PTR_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;

   localparam int DYN_W   = 3;
   localparam int STAT_W  = 3;
   localparam int OLVL_W  = 2;
   localparam int EXP_W   = 7;
   localparam logic [EXP_W-1:0] EXP_MAX = 7'd127;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_NEXT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [OLVL_W-1:0]  level;
      logic               swapped;
      logic               take;
   } result_type;

endpackage

@@ rtl/aeps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module aeps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/aeps_queue_ctrl.sv @@
// Queue pointers, fill counts, bank select and expired count; add/fetch decision.
module aeps_queue_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic                                 command,
   input  logic [aeps_pkg::ID_W-1:0]            task_id,
   input  logic signed [aeps_pkg::DYN_W-1:0]    dynamic_level,
   input  logic [aeps_pkg::STAT_W-1:0]          static_level,
   output logic                                 ram_wr_en,
   output logic [aeps_pkg::ADDR_W-1:0]          ram_wr_addr,
   output logic [aeps_pkg::ID_W-1:0]            ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [aeps_pkg::ADDR_W-1:0]          ram_rd_addr,
   output aeps_pkg::result_type                 result
);

   logic [aeps_pkg::PTR_W-1:0] head_ff [2][aeps_pkg::LEVELS];
   logic [aeps_pkg::PTR_W-1:0] head_in [2][aeps_pkg::LEVELS];
   logic [aeps_pkg::PTR_W-1:0] tail_ff [2][aeps_pkg::LEVELS];
   logic [aeps_pkg::PTR_W-1:0] tail_in [2][aeps_pkg::LEVELS];
   logic [aeps_pkg::CNT_W-1:0] fill_ff [2][aeps_pkg::LEVELS];
   logic [aeps_pkg::CNT_W-1:0] fill_in [2][aeps_pkg::LEVELS];
   logic                       bank_ff, bank_in;
   logic [aeps_pkg::EXP_W-1:0] exp_ff, exp_in;

   logic                       expired;
   logic signed [5:0]          target;
   logic                       in_range;
   logic                       add_bank;
   logic [aeps_pkg::LVL_W-1:0] add_lvl;
   logic                       full;
   logic                       act_has, oth_has;
   logic [aeps_pkg::LVL_W-1:0] act_lvl, oth_lvl;
   logic                       pop_bank;
   logic [aeps_pkg::LVL_W-1:0] pop_lvl;

   function automatic logic [aeps_pkg::PTR_W-1:0] bump(input logic [aeps_pkg::PTR_W-1:0] p);
      logic [aeps_pkg::PTR_W-1:0] r;
      r = (p == aeps_pkg::PTR_W'(aeps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   always_comb begin
      act_has = 1'b0;
      oth_has = 1'b0;
      act_lvl = '0;
      oth_lvl = '0;
      for (int i = 0; i < aeps_pkg::LEVELS; i++) begin
         if (fill_ff[bank_ff][i] != '0) begin
            act_has = 1'b1;
            act_lvl = aeps_pkg::LVL_W'(i);
         end
         if (fill_ff[~bank_ff][i] != '0) begin
            oth_has = 1'b1;
            oth_lvl = aeps_pkg::LVL_W'(i);
         end
      end
   end

   always_comb begin
      expired  = (dynamic_level == -3'sd1);
      target   = expired ? ($signed({3'b000, static_level}) - 6'sd1)
                         : 6'(dynamic_level);
      in_range = (target >= 6'sd0) && (target < 6'(aeps_pkg::LEVELS));
      add_bank = expired ? ~bank_ff : bank_ff;
      add_lvl  = aeps_pkg::LVL_W'(target);
      full     = (fill_ff[add_bank][add_lvl] == aeps_pkg::CNT_W'(aeps_pkg::QUEUE_DEPTH));
      pop_bank = bank_ff;
      pop_lvl  = act_lvl;

      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      bank_in = bank_ff;
      exp_in  = exp_ff;

      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_addr = {add_bank, add_lvl, tail_ff[add_bank][add_lvl]};
      ram_wr_data = task_id;
      ram_rd_addr = '0;

      result.status  = aeps_pkg::ST_OK;
      result.level   = '0;
      result.swapped = 1'b0;
      result.take    = 1'b0;

      if (command == aeps_pkg::CMD_ADD) begin
         if (!in_range) begin
            result.status = aeps_pkg::ST_RANGE;
         end else begin
            result.level = 2'(target);
            if (full) begin
               result.status = aeps_pkg::ST_FULL;
            end else begin
               ram_wr_en = go;
               tail_in[add_bank][add_lvl] = bump(tail_ff[add_bank][add_lvl]);
               fill_in[add_bank][add_lvl] = fill_ff[add_bank][add_lvl] + 1'b1;
               if (expired && (exp_ff != aeps_pkg::EXP_MAX)) begin
                  exp_in = exp_ff + 1'b1;
               end
            end
         end
      end else begin
         if (!act_has && (exp_ff != '0)) begin
            bank_in        = ~bank_ff;
            exp_in         = '0;
            result.swapped = 1'b1;
            pop_bank       = ~bank_ff;
            pop_lvl        = oth_lvl;
         end
         if (act_has || (result.swapped && oth_has)) begin
            result.take  = 1'b1;
            result.level = 2'(pop_lvl);
            ram_rd_en    = go;
            ram_rd_addr  = {pop_bank, pop_lvl, head_ff[pop_bank][pop_lvl]};
            head_in[pop_bank][pop_lvl] = bump(head_ff[pop_bank][pop_lvl]);
            fill_in[pop_bank][pop_lvl] = fill_ff[pop_bank][pop_lvl] - 1'b1;
         end else begin
            result.status = aeps_pkg::ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '{default: '0};
         tail_ff <= '{default: '0};
         fill_ff <= '{default: '0};
         bank_ff <= 1'b0;
         exp_ff  <= '0;
      end else if (go) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         exp_ff  <= exp_in;
      end
   end

endmodule

@@ rtl/active_expired_priority_scheduler_unit.sv @@
// Active/expired priority scheduler: command sequencer, task store and result register.
// An accepted item moves the sequencer into the read state, where the result register
// is loaded; the result strobe follows. Busy is high for the one cycle in which the
// task store read completes, and start is taken again while the result is shown.
// Reset: synchronous, active high; empties all queues, selects bank zero as active and
// clears the expired count. The task store itself is not cleared. The receiver cannot stall.
module active_expired_priority_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [aeps_pkg::ID_W-1:0]         req_task_id,
   input  logic signed [aeps_pkg::DYN_W-1:0] req_dynamic_level,
   input  logic [aeps_pkg::STAT_W-1:0]       req_static_level,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [aeps_pkg::ID_W-1:0]         rsp_chosen_id,
   output logic [aeps_pkg::OLVL_W-1:0]       rsp_level,
   output logic                              rsp_banks_swapped
);

   aeps_pkg::state_type  state_ff, state_in;
   aeps_pkg::result_type dec;
   aeps_pkg::result_type pend_ff;

   logic                        accept;
   logic                        ram_wr_en, ram_rd_en;
   logic [aeps_pkg::ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [aeps_pkg::ID_W-1:0]   ram_wr_data, ram_rd_data;

   logic                        valid_ff, valid_in;
   logic [1:0]                  status_ff;
   logic [aeps_pkg::ID_W-1:0]   chosen_ff;
   logic [aeps_pkg::OLVL_W-1:0] level_ff;
   logic                        swapped_ff;

   assign busy   = (state_ff == aeps_pkg::S_READ);
   assign accept = start && !busy;

   aeps_queue_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .go            (accept),
      .command       (req_command),
      .task_id       (req_task_id),
      .dynamic_level (req_dynamic_level),
      .static_level  (req_static_level),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .result        (dec)
   );

   aeps_ram #(
      .WIDTH (aeps_pkg::ID_W),
      .DEPTH (aeps_pkg::RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      case (state_ff)
         aeps_pkg::S_IDLE: begin
            if (start) begin
               state_in = aeps_pkg::S_READ;
            end
         end
         aeps_pkg::S_READ: begin
            valid_in = 1'b1;
            state_in = aeps_pkg::S_IDLE;
         end
         default: begin
            state_in = aeps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aeps_pkg::S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= dec;
      end
      if (busy) begin
         status_ff  <= pend_ff.status;
         chosen_ff  <= pend_ff.take ? ram_rd_data : '0;
         level_ff   <= pend_ff.level;
         swapped_ff <= pend_ff.swapped;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_chosen_id     = chosen_ff;
   assign rsp_level         = level_ff;
   assign rsp_banks_swapped = swapped_ff;

endmodule

@@ rtl/aeps_checker.sv @@
// Port-level assertions for the scheduler, bound to the top level.
module aeps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [1:0]                        rsp_status,
   input logic [aeps_pkg::ID_W-1:0]         rsp_chosen_id,
   input logic [aeps_pkg::OLVL_W-1:0]       rsp_level,
   input logic                              rsp_banks_swapped
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no result two cycles after accept");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid))
      else $error("result strobe held longer than one cycle");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == aeps_pkg::ST_EMPTY))
         |-> (rsp_chosen_id == '0) && (rsp_level == '0))
      else $error("empty fetch carries a task");

   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == aeps_pkg::ST_RANGE))
         |-> (rsp_chosen_id == '0) && (rsp_level == '0) && !rsp_banks_swapped)
      else $error("range error result has stray fields");

endmodule

bind active_expired_priority_scheduler_unit aeps_checker u_aeps_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_chosen_id     (rsp_chosen_id),
   .rsp_level         (rsp_level),
   .rsp_banks_swapped (rsp_banks_swapped)
);
